/* rtl/core/hang_metric_threshold_monitor_top_macros.svh */
`ifndef HANG_METRIC_THRESHOLD_MONITOR_TOP_MACROS_SVH
`define HANG_METRIC_THRESHOLD_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HMTM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmtm check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define HMTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmtm check failed");

`endif

/* rtl/core/hmtm_pkg.sv */
`default_nettype none

package hmtm_pkg;

    localparam int MAX_CPUS = 64;
    localparam int POS_W    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic CMD_CPU = 1'b0;
    localparam logic CMD_SYS = 1'b1;

    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_CPU  = 2'd1;
    localparam logic [1:0] CODE_MEM  = 2'd2;
    localparam logic [1:0] CODE_PROC = 2'd3;

    localparam logic [2:0] REG_SYS_LIMIT     = 3'd0;
    localparam logic [2:0] REG_USR_LIMIT     = 3'd1;
    localparam logic [2:0] REG_IOWAIT_LIMIT  = 3'd2;
    localparam logic [2:0] REG_MEMFREE_LIMIT = 3'd3;
    localparam logic [2:0] REG_RUN_LIMIT     = 3'd4;
    localparam logic [2:0] REG_CS_LIMIT      = 3'd5;
    localparam logic [2:0] REG_CPU_PERSIST   = 3'd6;
    localparam logic [2:0] REG_MEM_PERSIST   = 3'd7;

    localparam logic [6:0]  RST_SYS_LIMIT     = 7'd50;
    localparam logic [6:0]  RST_USR_LIMIT     = 7'd4;
    localparam logic [6:0]  RST_IOWAIT_LIMIT  = 7'd50;
    localparam logic [23:0] RST_MEMFREE_LIMIT = 24'd30720;
    localparam logic [15:0] RST_RUN_LIMIT     = 16'd4;
    localparam logic [23:0] RST_CS_LIMIT      = 24'd25;
    localparam logic [2:0]  RST_CPU_PERSIST   = 3'd2;
    localparam logic [2:0]  RST_MEM_PERSIST   = 3'd2;

    localparam logic [2:0] STREAK_MAX = 3'd7;

    typedef struct packed {
        logic        command;
        logic [6:0]  cpu_sys;
        logic [6:0]  cpu_usr;
        logic [6:0]  cpu_iowait;
        logic [23:0] mem_free;
        logic [15:0] run_queue;
        logic [23:0] context_switches;
    } hmtm_in_t;

    typedef struct packed {
        logic [1:0] code;
        logic [5:0] cpu_index;
        logic       last;
    } hmtm_out_t;

    typedef struct packed {
        logic [6:0]  sys_limit;
        logic [6:0]  usr_limit;
        logic [6:0]  iowait_limit;
        logic [23:0] memfree_limit;
        logic [15:0] run_limit;
        logic [23:0] cs_limit;
        logic [2:0]  cpu_persist;
        logic [2:0]  mem_persist;
    } hmtm_cfg_t;

    // Results of one record, n of them (0..2), r0 first.
    typedef struct packed {
        logic [1:0] n;
        hmtm_out_t  r0;
        hmtm_out_t  r1;
    } hmtm_push_t;

endpackage

`default_nettype wire

/* rtl/core/hmtm_core.sv */
`default_nettype none

module hmtm_core
    import hmtm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire hmtm_in_t   in_data,
    input  wire hmtm_cfg_t  cfg,
    input  wire logic       room,
    output hmtm_push_t      push
);

    logic       item_valid_reg, item_valid_next;
    hmtm_in_t   item_reg;
    logic [2:0] cpu_streak_reg, cpu_streak_next;
    logic [2:0] mem_streak_reg, mem_streak_next;
    logic       suspect_seen_reg, suspect_seen_next;
    logic       reported_reg, reported_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic proc, accept;
    logic suspect, streak_hit, iow_hit, cpu_emit;
    logic mem_low, mem_emit, proc_emit, none_emit;
    hmtm_out_t cpu_res, mem_res, proc_res, none_res;

    assign proc     = item_valid_reg && room;
    assign in_stall = item_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        suspect    = (item_reg.cpu_sys > cfg.sys_limit) && (item_reg.cpu_usr < cfg.usr_limit);
        streak_hit = cpu_streak_reg >= cfg.cpu_persist;
        iow_hit    = item_reg.cpu_iowait > cfg.iowait_limit;
        cpu_emit   = (suspect && streak_hit) || (!reported_reg && iow_hit);

        mem_low   = item_reg.mem_free < cfg.memfree_limit;
        mem_emit  = mem_low && (mem_streak_reg >= cfg.mem_persist);
        proc_emit = (item_reg.run_queue > cfg.run_limit)
                    || (item_reg.context_switches < cfg.cs_limit);
        none_emit = !(reported_reg || mem_emit || proc_emit);

        cpu_res  = '{code: CODE_CPU,  cpu_index: 6'(pos_reg), last: 1'b1};
        mem_res  = '{code: CODE_MEM,  cpu_index: 6'd0, last: 1'b1};
        proc_res = '{code: CODE_PROC, cpu_index: 6'd0, last: 1'b1};
        none_res = '{code: CODE_NONE, cpu_index: 6'd0, last: 1'b1};

        item_valid_next   = accept ? 1'b1 : (proc ? 1'b0 : item_valid_reg);
        cpu_streak_next   = cpu_streak_reg;
        mem_streak_next   = mem_streak_reg;
        suspect_seen_next = suspect_seen_reg;
        reported_next     = reported_reg;
        pos_next          = pos_reg;

        push    = '0;
        push.r0 = cpu_res;
        push.r1 = proc_res;

        if (proc)
        begin
            if (item_reg.command == CMD_CPU)
            begin
                if (suspect && !streak_hit)
                    suspect_seen_next = 1'b1;
                if (cpu_emit)
                begin
                    reported_next = 1'b1;
                    push.n        = 2'd1;
                end
                if (pos_reg < POS_W'(MAX_CPUS - 1))
                    pos_next = pos_reg + 1'b1;
            end
            else
            begin
                if (suspect_seen_reg)
                    cpu_streak_next = (cpu_streak_reg < STREAK_MAX)
                                      ? cpu_streak_reg + 3'd1 : cpu_streak_reg;
                else
                    cpu_streak_next = 3'd0;

                if (!mem_low)
                    mem_streak_next = 3'd0;
                else if (!mem_emit && (mem_streak_reg < STREAK_MAX))
                    mem_streak_next = mem_streak_reg + 3'd1;

                if (mem_emit && proc_emit)
                begin
                    push.n         = 2'd2;
                    push.r0        = mem_res;
                    push.r0.last   = 1'b0;
                    push.r1        = proc_res;
                end
                else
                begin
                    push.n  = 2'd1;
                    push.r0 = mem_emit ? mem_res : (proc_emit ? proc_res : none_res);
                    if (!mem_emit && !proc_emit && !none_emit)
                        push.n = 2'd0;
                end

                suspect_seen_next = 1'b0;
                reported_next     = 1'b0;
                pos_next          = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            cpu_streak_reg   <= 3'd0;
            mem_streak_reg   <= 3'd0;
            suspect_seen_reg <= 1'b0;
            reported_reg     <= 1'b0;
            pos_reg          <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            cpu_streak_reg   <= cpu_streak_next;
            mem_streak_reg   <= mem_streak_next;
            suspect_seen_reg <= suspect_seen_next;
            reported_reg     <= reported_next;
            pos_reg          <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
    end

endmodule

`default_nettype wire

/* rtl/core/hmtm_out_fifo.sv */
`default_nettype none

module hmtm_out_fifo
    import hmtm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire hmtm_push_t  push,
    output logic             room,
    output logic             out_valid,
    input  wire logic        out_stall,
    output hmtm_out_t        out_data
);

    hmtm_out_t mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;
    logic [FIFO_AW-1:0] wr_ptr_p1;

    assign room      = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.n);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem_reg[wr_ptr_p1] <= push.r1;
    end

endmodule

`default_nettype wire

/* rtl/core/hang_metric_threshold_monitor_top.sv */
// Hang metric threshold monitor.
// Input channel (in_valid/in_stall/in_data): one beat per record, CPU records
// of a snapshot first, then one system record that closes it.
// Output channel (out_valid/out_stall/out_data): result beats; last marks the
// final result of a record. CPU records give 0 or 1 beat, system records 0 to 2.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no record is in flight.
// A record is registered in the core on acceptance and evaluated from that
// register into a 4-entry result queue, from which its beats are read.
// Throughput: one record per cycle, bounded by the output side at one beat per
// cycle; a held record stalls the input while the queue has under two free slots.
// A stalled output holds its beat; the queue keeps absorbing until it runs short.
// Reset clears streaks, snapshot state and the queue and loads the default
// thresholds.
`default_nettype none

module hang_metric_threshold_monitor_top
    import hmtm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire hmtm_in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output hmtm_out_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

`include "hang_metric_threshold_monitor_top_macros.svh"

    hmtm_cfg_t  cfg_reg, cfg_next;
    hmtm_push_t push;
    logic       room;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SYS_LIMIT:     cfg_next.sys_limit     = cfg_data[6:0];
                REG_USR_LIMIT:     cfg_next.usr_limit     = cfg_data[6:0];
                REG_IOWAIT_LIMIT:  cfg_next.iowait_limit  = cfg_data[6:0];
                REG_MEMFREE_LIMIT: cfg_next.memfree_limit = cfg_data[23:0];
                REG_RUN_LIMIT:     cfg_next.run_limit     = cfg_data[15:0];
                REG_CS_LIMIT:      cfg_next.cs_limit      = cfg_data[23:0];
                REG_CPU_PERSIST:   cfg_next.cpu_persist   = cfg_data[2:0];
                REG_MEM_PERSIST:   cfg_next.mem_persist   = cfg_data[2:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sys_limit     <= RST_SYS_LIMIT;
            cfg_reg.usr_limit     <= RST_USR_LIMIT;
            cfg_reg.iowait_limit  <= RST_IOWAIT_LIMIT;
            cfg_reg.memfree_limit <= RST_MEMFREE_LIMIT;
            cfg_reg.run_limit     <= RST_RUN_LIMIT;
            cfg_reg.cs_limit      <= RST_CS_LIMIT;
            cfg_reg.cpu_persist   <= RST_CPU_PERSIST;
            cfg_reg.mem_persist   <= RST_MEM_PERSIST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hmtm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .room     (room),
        .push     (push)
    );

    hmtm_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `HMTM_ASSERT_SAME(a_pair_order, push.n == 2'd2,
        !push.r0.last && push.r1.last && push.r0.code == CODE_MEM && push.r1.code == CODE_PROC)
    `HMTM_ASSERT_SAME(a_single_last, push.n == 2'd1, push.r0.last)
    `HMTM_ASSERT_SAME(a_index_only_cpu, out_valid && out_data.code != CODE_CPU,
        out_data.cpu_index == 6'd0)
    `HMTM_ASSERT_SAME(a_stall_no_push, in_stall, push.n == 2'd0)

endmodule

`default_nettype wire

/* bench/hang_metric_threshold_monitor_top_tb.sv */
`default_nettype none

module hang_metric_threshold_monitor_top_tb
    import hmtm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 1000;
    localparam int MAX_SHOWN   = 10;

    typedef enum {TH_DEFAULT, TH_TYPICAL, TH_LOW, TH_HIGH, TH_WIDE} th_mix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    hmtm_in_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    hmtm_out_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    hmtm_in_t  records_pending[$];
    hmtm_out_t alarms_due[$];

    int records_queued = 0;
    int records_taken  = 0;
    int beats_seen     = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int settings       = 1;
    int code_hits[4]   = '{default: 0};
    int send_gap_pct   = 0;
    int stall_pct      = 0;

    // thresholds as loaded into the block, and the snapshot tracking state
    hmtm_cfg_t th = '{
        sys_limit:     RST_SYS_LIMIT,
        usr_limit:     RST_USR_LIMIT,
        iowait_limit:  RST_IOWAIT_LIMIT,
        memfree_limit: RST_MEMFREE_LIMIT,
        run_limit:     RST_RUN_LIMIT,
        cs_limit:      RST_CS_LIMIT,
        cpu_persist:   RST_CPU_PERSIST,
        mem_persist:   RST_MEM_PERSIST
    };
    logic [2:0] cpu_run       = '0;
    logic [2:0] mem_run       = '0;
    logic       cpu_flagged   = 1'b0;
    logic       snap_reported = 1'b0;
    int         cpu_slot      = 0;

    hang_metric_threshold_monitor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void predict_alarms(input hmtm_in_t rec);
        hmtm_out_t burst [2];
        int        n;
        bit        streak_hit;
        n = 0;
        streak_hit = 1'b0;
        if (rec.command == CMD_CPU)
        begin
            if (rec.cpu_sys > th.sys_limit && rec.cpu_usr < th.usr_limit)
            begin
                if (cpu_run >= th.cpu_persist)
                begin
                    burst[n] = '{code: CODE_CPU, cpu_index: 6'(cpu_slot), last: 1'b0};
                    n++;
                    snap_reported = 1'b1;
                    streak_hit = 1'b1;
                end
                else
                begin
                    cpu_flagged = 1'b1;
                end
            end
            // one report per snapshot from I/O wait, never twice on one record
            if (!streak_hit && !snap_reported && rec.cpu_iowait > th.iowait_limit)
            begin
                burst[n] = '{code: CODE_CPU, cpu_index: 6'(cpu_slot), last: 1'b0};
                n++;
                snap_reported = 1'b1;
            end
            if (cpu_slot < MAX_CPUS - 1)
                cpu_slot++;
        end
        else
        begin
            if (cpu_flagged)
            begin
                if (cpu_run < STREAK_MAX)
                    cpu_run++;
            end
            else
            begin
                cpu_run = '0;
            end
            if (rec.mem_free < th.memfree_limit)
            begin
                if (mem_run >= th.mem_persist)
                begin
                    burst[n] = '{code: CODE_MEM, cpu_index: 6'd0, last: 1'b0};
                    n++;
                    snap_reported = 1'b1;
                end
                else if (mem_run < STREAK_MAX)
                begin
                    mem_run++;
                end
            end
            else
            begin
                mem_run = '0;
            end
            if (rec.run_queue > th.run_limit || rec.context_switches < th.cs_limit)
            begin
                burst[n] = '{code: CODE_PROC, cpu_index: 6'd0, last: 1'b0};
                n++;
                snap_reported = 1'b1;
            end
            if (!snap_reported)
            begin
                burst[n] = '{code: CODE_NONE, cpu_index: 6'd0, last: 1'b0};
                n++;
            end
            cpu_flagged = 1'b0;
            snap_reported = 1'b0;
            cpu_slot = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            burst[i].last = (i == n - 1);
            alarms_due.push_back(burst[i]);
        end
    endfunction

    function automatic hmtm_in_t cpu_beat(input logic [6:0] sys, input logic [6:0] usr,
                                          input logic [6:0] iow);
        hmtm_in_t r;
        r.command          = CMD_CPU;
        r.cpu_sys          = sys;
        r.cpu_usr          = usr;
        r.cpu_iowait       = iow;
        r.mem_free         = 24'($urandom);
        r.run_queue        = 16'($urandom);
        r.context_switches = 24'($urandom);
        return r;
    endfunction

    function automatic hmtm_in_t sys_beat(input logic [23:0] memf, input logic [15:0] runq,
                                          input logic [23:0] csw);
        hmtm_in_t r;
        r.command          = CMD_SYS;
        r.cpu_sys          = 7'($urandom);
        r.cpu_usr          = 7'($urandom);
        r.cpu_iowait       = 7'($urandom);
        r.mem_free         = memf;
        r.run_queue        = runq;
        r.context_switches = csw;
        return r;
    endfunction

    // value at or next to a threshold, or anywhere
    function automatic logic [23:0] around(input logic [23:0] lim, input logic [23:0] span);
        case ($urandom_range(4))
            0: return lim - 24'd1;
            1: return lim;
            2: return lim + 24'd1;
            3: return 24'($urandom);
            default: return 24'($urandom_range(0, span));
        endcase
    endfunction

    function automatic void queue_record(input hmtm_in_t r);
        records_pending.push_back(r);
        records_queued++;
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SYS_LIMIT:     th.sys_limit     = value[6:0];
            REG_USR_LIMIT:     th.usr_limit     = value[6:0];
            REG_IOWAIT_LIMIT:  th.iowait_limit  = value[6:0];
            REG_MEMFREE_LIMIT: th.memfree_limit = value;
            REG_RUN_LIMIT:     th.run_limit     = value[15:0];
            REG_CS_LIMIT:      th.cs_limit      = value;
            REG_CPU_PERSIST:   th.cpu_persist   = value[2:0];
            REG_MEM_PERSIST:   th.mem_persist   = value[2:0];
            default: ;
        endcase
    endtask

    // hold the sender until every record is taken and every result is back
    task automatic settle(input int tail);
        while (records_taken != records_queued || alarms_due.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic run_phase(input th_mix_t mix, input int n_items, input int gap,
                             input int stall);
        hmtm_cfg_t target;
        hmtm_in_t  rec;
        int        start;
        int        n_cpu;
        bit        hot_cpu;
        bit        hot_mem;
        target = th;
        case (mix)
            TH_TYPICAL:
            begin
                target.sys_limit     = 7'($urandom_range(30, 90));
                target.usr_limit     = 7'($urandom_range(2, 30));
                target.iowait_limit  = 7'($urandom_range(30, 95));
                target.memfree_limit = 24'($urandom_range(0, 100000));
                target.run_limit     = 16'($urandom_range(0, 64));
                target.cs_limit      = 24'($urandom_range(0, 5000));
                target.cpu_persist   = 3'($urandom_range(0, 4));
                target.mem_persist   = 3'($urandom_range(0, 4));
            end
            TH_LOW:
                target = '{7'd0, 7'd100, 7'd0, 24'd0, 16'd0, 24'd0, 3'd0, 3'd0};
            TH_HIGH:
                target = '{7'h7F, 7'h7F, 7'h7F, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 3'd7, 3'd7};
            TH_WIDE:
            begin
                target.sys_limit     = 7'($urandom);
                target.usr_limit     = 7'($urandom);
                target.iowait_limit  = 7'($urandom);
                target.memfree_limit = 24'($urandom);
                target.run_limit     = 16'($urandom);
                target.cs_limit      = 24'($urandom);
                target.cpu_persist   = 3'($urandom);
                target.mem_persist   = 3'($urandom);
            end
            default: ;
        endcase
        if (mix != TH_DEFAULT)
        begin
            write_reg(REG_SYS_LIMIT, 24'(target.sys_limit));
            write_reg(REG_USR_LIMIT, 24'(target.usr_limit));
            write_reg(REG_IOWAIT_LIMIT, 24'(target.iowait_limit));
            write_reg(REG_MEMFREE_LIMIT, target.memfree_limit);
            write_reg(REG_RUN_LIMIT, 24'(target.run_limit));
            write_reg(REG_CS_LIMIT, target.cs_limit);
            write_reg(REG_CPU_PERSIST, 24'(target.cpu_persist));
            write_reg(REG_MEM_PERSIST, 24'(target.mem_persist));
            settings++;
        end
        send_gap_pct = gap;
        stall_pct = stall;
        start = records_queued;
        hot_cpu = 1'b0;
        hot_mem = 1'b0;
        while (records_queued - start < n_items)
        begin
            // suspect runs persist over several snapshots so the streaks build up
            if ($urandom_range(3) == 0)
                hot_cpu = !hot_cpu;
            if ($urandom_range(3) == 0)
                hot_mem = !hot_mem;
            n_cpu = ($urandom_range(99) < 3) ? $urandom_range(60, 70) : $urandom_range(0, 6);
            for (int i = 0; i < n_cpu; i++)
            begin
                if ($urandom_range(99) < 5)
                begin
                    rec = cpu_beat(7'($urandom), 7'($urandom), 7'($urandom));
                    rec.command = 1'($urandom);
                end
                else if (hot_cpu && $urandom_range(99) < 60)
                begin
                    rec = cpu_beat(7'(th.sys_limit + 7'd1 + 7'($urandom_range(0, 20))),
                                   th.usr_limit == 0 ? 7'd0
                                                     : 7'($urandom_range(0, th.usr_limit - 1)),
                                   7'(around(24'(th.iowait_limit), 24'd127)));
                end
                else
                begin
                    rec = cpu_beat(7'(around(24'(th.sys_limit), 24'd100)),
                                   7'(around(24'(th.usr_limit), 24'd100)),
                                   $urandom_range(1) ? 7'($urandom_range(0, th.iowait_limit))
                                                     : 7'(around(24'(th.iowait_limit), 24'd127)));
                end
                queue_record(rec);
            end
            rec = sys_beat(hot_mem ? (th.memfree_limit == 0 ? 24'd0
                                      : 24'($urandom_range(0, th.memfree_limit - 1)))
                                   : around(th.memfree_limit, 24'd100000),
                           $urandom_range(2) == 0 ? 16'(around(24'(th.run_limit), 24'd256))
                                                  : 16'($urandom_range(0, th.run_limit)),
                           $urandom_range(2) == 0 ? around(th.cs_limit, 24'd10000)
                                                  : 24'($urandom_range(th.cs_limit, 24'hFFFFFF)));
            queue_record(rec);
        end
        settle(4);
    endtask

    // sender: one beat per free slot, with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_alarms(in_data);
                records_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (records_pending.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_data  <= records_pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall, every accepted beat checked against the oldest alarm due
    always @(posedge clk)
    begin
        hmtm_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (alarms_due.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected beat code %0d cpu %0d last %0d",
                                           out_data.code, out_data.cpu_index, out_data.last));
                end
                else
                begin
                    want = alarms_due.pop_front();
                    code_hits[want.code]++;
                    if (out_data.code !== want.code || out_data.cpu_index !== want.cpu_index
                        || out_data.last !== want.last)
                        log_mismatch($sformatf(
                            "beat %0d expected code %0d cpu %0d last %0d, got %0d/%0d/%0d",
                            beats_seen, want.code, want.cpu_index, want.last,
                            out_data.code, out_data.cpu_index, out_data.last));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        send_gap_pct = 22;
        stall_pct = 50;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed snapshots under the reset thresholds
        queue_record(sys_beat(24'hFFFFFF, 16'd0, 24'hFFFFFF));
        queue_record(cpu_beat(7'd0, 7'd0, 7'd0));
        queue_record(cpu_beat(7'd127, 7'd127, 7'd127));
        queue_record(sys_beat(24'd0, 16'hFFFF, 24'd0));
        queue_record(cpu_beat(7'd100, 7'd0, 7'd0));
        queue_record(sys_beat(24'd0, 16'd4, 24'd25));
        queue_record(cpu_beat(7'd51, 7'd3, 7'd50));
        queue_record(sys_beat(24'd0, 16'd0, 24'd30720));
        // I/O wait report, then streak report on the next CPU, then nothing more
        queue_record(cpu_beat(7'd10, 7'd10, 7'd51));
        queue_record(cpu_beat(7'd101, 7'd0, 7'd100));
        queue_record(cpu_beat(7'd0, 7'd0, 7'd127));
        queue_record(sys_beat(24'd30720, 16'd5, 24'd24));
        queue_record(cpu_beat(7'd127, 7'd0, 7'd0));
        queue_record(cpu_beat(7'd50, 7'd3, 7'd51));
        queue_record(sys_beat(24'd30719, 16'd0, 24'hFFFFFF));
        queue_record(sys_beat(24'd30720, 16'd4, 24'd25));

        run_phase(TH_DEFAULT, 300, 22, 50);
        run_phase(TH_TYPICAL, 330, 22, 50);
        run_phase(TH_LOW, 330, 50, 22);
        run_phase(TH_HIGH, 330, 50, 22);
        run_phase(TH_WIDE, 330, 0, 0);
        run_phase(TH_TYPICAL, 330, 0, 0);
        settle(8);

        $display("checked %0d records and %0d result beats (none %0d, cpu %0d, mem %0d, proc %0d)",
                 records_taken, beats_seen, code_hits[CODE_NONE], code_hits[CODE_CPU],
                 code_hits[CODE_MEM], code_hits[CODE_PROC]);
        $display("over %0d threshold settings, with idling on either side and on neither",
                 settings);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

/* hang_metric_threshold_monitor_top.f */
+incdir+rtl/core
rtl/core/hmtm_pkg.sv
rtl/core/hmtm_core.sv
rtl/core/hmtm_out_fifo.sv
rtl/core/hang_metric_threshold_monitor_top.sv
bench/hang_metric_threshold_monitor_top_tb.sv
